@@ sv/lli_pkg.sv @@
// ----------------------------------------------------------------------------
// lli_pkg
// Types, constants and helpers shared by the layered network inference block.
// ----------------------------------------------------------------------------
package lli_pkg;

    localparam int MAX_LAYERS   = 4;
    localparam int MAX_NEURONS  = 8;
    localparam int VALUE_BITS   = 16;
    localparam int IDX_BITS     = 3;
    localparam int LAYER_BITS   = 2;
    localparam int SIZE_BITS    = 4;
    localparam int COUNT_BITS   = 3;
    localparam int BANK_BITS    = 2;
    localparam int PROD_BITS    = 2 * VALUE_BITS;
    localparam int ACC_BITS     = PROD_BITS + 4;
    localparam int FRAC_BITS    = 8;
    localparam int SHIFT_BITS   = ACC_BITS - FRAC_BITS;

    localparam int WEIGHT_DEPTH = (MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS;
    localparam int VEC_DEPTH    = 3 * MAX_NEURONS;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 4;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LAYER_COUNT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIZE_ZERO   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIZE_ONE    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIZE_TWO    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SIZE_THREE  = 3'd4;

    localparam logic [COUNT_BITS-1:0] LAYER_COUNT_RESET = 3'd3;
    localparam logic [COUNT_BITS-1:0] LAYER_COUNT_MIN   = 3'd2;
    localparam logic [COUNT_BITS-1:0] LAYER_COUNT_MAX   = 3'd4;
    localparam logic [SIZE_BITS-1:0]  SIZE_RESET        = 4'd8;
    localparam logic [SIZE_BITS-1:0]  SIZE_MAX          = 4'd8;

    // operation codes
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_INPUT  = 1'b1;

    localparam logic [LAYER_BITS-1:0] LAST_SOURCE_LAYER = 2'd2;

    // vector store banks
    localparam logic [BANK_BITS-1:0] BANK_INPUT = 2'd0;
    localparam logic [BANK_BITS-1:0] BANK_A     = 2'd1;
    localparam logic [BANK_BITS-1:0] BANK_B     = 2'd2;

    typedef struct packed {
        logic                          operation;
        logic [LAYER_BITS-1:0]         layer_sel;
        logic [IDX_BITS-1:0]           source_index;
        logic [IDX_BITS-1:0]           target_index;
        logic signed [VALUE_BITS-1:0]  value;
        logic                          vector_end;
    } in_word_t;

    typedef struct packed {
        logic [IDX_BITS-1:0]           out_index;
        logic signed [VALUE_BITS-1:0]  out_value;
        logic                          out_last;
        logic                          out_saturated;
    } out_word_t;

    typedef struct packed {
        logic                   wr_weight;
        logic                   wr_input;
        logic                   mac_issue;
        logic                   mac_first;
        logic [BANK_BITS-1:0]   rd_bank;
        logic [IDX_BITS-1:0]    rd_idx;
        logic [LAYER_BITS-1:0]  w_layer;
        logic [IDX_BITS-1:0]    w_src;
        logic [IDX_BITS-1:0]    w_tgt;
        logic                   wb_en;
        logic [BANK_BITS-1:0]   wb_bank;
        logic [IDX_BITS-1:0]    wb_idx;
        logic                   sat_clear;
        logic                   out_load;
        logic [IDX_BITS-1:0]    out_idx;
        logic                   out_last;
    } dp_cmd_t;

    // zero counts as one, above the neuron limit counts as the limit
    function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
        logic [SIZE_BITS-1:0] r;
        r = s;
        if (s == '0)
        begin
            r = 4'd1;
        end
        else if (s > SIZE_MAX)
        begin
            r = SIZE_MAX;
        end
        return r;
    endfunction

endpackage

@@ sv/lli_ram.sv @@
// ----------------------------------------------------------------------------
// lli_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lli_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/lli_datapath.sv @@
// ----------------------------------------------------------------------------
// lli_datapath
// Weight and vector stores, multiply-accumulate pipeline, scaling with
// saturation and the result register.
// ----------------------------------------------------------------------------
module lli_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  lli_pkg::in_word_t  in_data,
    input  lli_pkg::dp_cmd_t   cmd,
    output lli_pkg::out_word_t out_data
);
    import lli_pkg::*;

    logic [VALUE_BITS-1:0]          w_rd_data;
    logic [VALUE_BITS-1:0]          v_rd_data;
    logic [7:0]                     w_wr_addr;
    logic [7:0]                     w_rd_addr;
    logic [4:0]                     v_wr_addr;
    logic [4:0]                     v_rd_addr;
    logic                           v_wr_en;
    logic [VALUE_BITS-1:0]          v_wr_data;

    logic                           p1_valid_reg;
    logic                           p1_first_reg;
    logic                           p2_valid_reg;
    logic                           p2_first_reg;
    logic signed [PROD_BITS-1:0]    prod_reg;
    logic signed [ACC_BITS-1:0]     acc_reg;
    logic signed [ACC_BITS-1:0]     acc_next;
    logic                           sat_reg;
    logic                           sat_next;
    out_word_t                      out_reg;

    logic signed [SHIFT_BITS-1:0]   shifted;
    logic [VALUE_BITS-1:0]          scaled;
    logic                           wb_sat;

    assign w_wr_addr = {in_data.layer_sel, in_data.source_index, in_data.target_index};
    assign w_rd_addr = {cmd.w_layer, cmd.w_src, cmd.w_tgt};
    assign v_rd_addr = {cmd.rd_bank, cmd.rd_idx};

    lli_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (WEIGHT_DEPTH)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_weight),
        .wr_addr (w_wr_addr),
        .wr_data (in_data.value),
        .rd_addr (w_rd_addr),
        .rd_data (w_rd_data)
    );

    lli_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (VEC_DEPTH)
    ) u_vector_ram (
        .clk     (clk),
        .wr_en   (v_wr_en),
        .wr_addr (v_wr_addr),
        .wr_data (v_wr_data),
        .rd_addr (v_rd_addr),
        .rd_data (v_rd_data)
    );

    // floor divide by 256, then saturate
    always_comb
    begin
        shifted = SHIFT_BITS'(acc_reg >>> FRAC_BITS);
        scaled  = shifted[VALUE_BITS-1:0];
        wb_sat  = 1'b0;
        if (shifted > SHIFT_BITS'(signed'({1'b0, {(VALUE_BITS-1){1'b1}}})))
        begin
            scaled = {1'b0, {(VALUE_BITS-1){1'b1}}};
            wb_sat = 1'b1;
        end
        else if (shifted < -SHIFT_BITS'(signed'({1'b0, 1'b1, {(VALUE_BITS-1){1'b0}}})))
        begin
            scaled = {1'b1, {(VALUE_BITS-1){1'b0}}};
            wb_sat = 1'b1;
        end
    end

    always_comb
    begin
        v_wr_en   = cmd.wb_en | cmd.wr_input;
        v_wr_addr = {BANK_INPUT, in_data.source_index};
        v_wr_data = in_data.value;
        if (cmd.wb_en)
        begin
            v_wr_addr = {cmd.wb_bank, cmd.wb_idx};
            v_wr_data = scaled;
        end
    end

    always_comb
    begin
        acc_next = acc_reg + ACC_BITS'(prod_reg);
        if (p2_first_reg)
        begin
            acc_next = ACC_BITS'(prod_reg);
        end
    end

    always_comb
    begin
        sat_next = sat_reg;
        if (cmd.sat_clear)
        begin
            sat_next = 1'b0;
        end
        else if (cmd.wb_en && wb_sat)
        begin
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p1_first_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p2_first_reg <= 1'b0;
            sat_reg      <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cmd.mac_issue;
            p1_first_reg <= cmd.mac_first;
            p2_valid_reg <= p1_valid_reg;
            p2_first_reg <= p1_first_reg;
            sat_reg      <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            prod_reg <= $signed(v_rd_data) * $signed(w_rd_data);
        end
        if (p2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.out_load)
        begin
            out_reg.out_index     <= cmd.out_idx;
            out_reg.out_value     <= v_rd_data;
            out_reg.out_last      <= cmd.out_last;
            out_reg.out_saturated <= sat_reg;
        end
    end

    assign out_data = out_reg;

endmodule

@@ sv/lli_controller.sv @@
// ----------------------------------------------------------------------------
// lli_controller
// Configuration registers, input handshake and the layer, target and source
// sequencer that drives the datapath.
// ----------------------------------------------------------------------------
module lli_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  lli_pkg::in_word_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic                                 cfg_wr_en,
    input  logic [lli_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [lli_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output lli_pkg::dp_cmd_t                     cmd
);
    import lli_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_MAC      = 7'b0000010,
        ST_DRAIN    = 7'b0000100,
        ST_WB       = 7'b0001000,
        ST_OUT_RD   = 7'b0010000,
        ST_OUT_LOAD = 7'b0100000,
        ST_OUT_SEND = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [LAYER_BITS-1:0]   layer_reg, layer_next;
    logic [IDX_BITS-1:0]     j_reg, j_next;
    logic [IDX_BITS-1:0]     k_reg, k_next;
    logic                    drain_reg, drain_next;
    logic [BANK_BITS-1:0]    src_bank_reg, src_bank_next;
    logic [BANK_BITS-1:0]    dst_bank_reg, dst_bank_next;
    logic [COUNT_BITS-1:0]   layer_count_reg;
    logic [SIZE_BITS-1:0]    size_reg [MAX_LAYERS];

    logic [COUNT_BITS-1:0]   layers;
    logic [LAYER_BITS-1:0]   out_layer;
    logic [SIZE_BITS-1:0]    ns;
    logic [SIZE_BITS-1:0]    nt;
    logic [SIZE_BITS-1:0]    n_out;
    logic                    last_j;
    logic                    last_k;
    logic                    last_layer;
    logic                    last_out;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_count_reg <= LAYER_COUNT_RESET;
            for (int i = 0; i < MAX_LAYERS; i++)
            begin
                size_reg[i] <= SIZE_RESET;
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LAYER_COUNT: layer_count_reg <= cfg_data[COUNT_BITS-1:0];
                CFG_SIZE_ZERO:   size_reg[0]     <= cfg_data;
                CFG_SIZE_ONE:    size_reg[1]     <= cfg_data;
                CFG_SIZE_TWO:    size_reg[2]     <= cfg_data;
                CFG_SIZE_THREE:  size_reg[3]     <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        layers = layer_count_reg;
        if (layer_count_reg < LAYER_COUNT_MIN)
        begin
            layers = LAYER_COUNT_MIN;
        end
        else if (layer_count_reg > LAYER_COUNT_MAX)
        begin
            layers = LAYER_COUNT_MAX;
        end
    end

    assign out_layer  = LAYER_BITS'(layers - 3'd1);
    assign ns         = eff_size(size_reg[layer_reg]);
    assign nt         = eff_size(size_reg[layer_reg + 2'd1]);
    assign n_out      = eff_size(size_reg[out_layer]);
    assign last_j     = ({1'b0, j_reg} == ns - 4'd1);
    assign last_k     = ({1'b0, k_reg} == nt - 4'd1);
    assign last_out   = ({1'b0, k_reg} == n_out - 4'd1);
    assign last_layer = ({1'b0, layer_reg} == layers - 3'd2);

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT_SEND);

    always_comb
    begin
        state_next    = state_reg;
        layer_next    = layer_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        drain_next    = drain_reg;
        src_bank_next = src_bank_reg;
        dst_bank_next = dst_bank_reg;
        cmd           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.operation == OP_INPUT)
                    begin
                        cmd.wr_input = 1'b1;
                        if (in_data.vector_end)
                        begin
                            cmd.sat_clear = 1'b1;
                            layer_next    = '0;
                            j_next        = '0;
                            k_next        = '0;
                            src_bank_next = BANK_INPUT;
                            dst_bank_next = BANK_A;
                            state_next    = ST_MAC;
                        end
                    end
                    else
                    begin
                        cmd.wr_weight = (in_data.layer_sel <= LAST_SOURCE_LAYER);
                    end
                end
            end

            ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
                cmd.mac_first = (j_reg == '0);
                cmd.rd_bank   = src_bank_reg;
                cmd.rd_idx    = j_reg;
                cmd.w_layer   = layer_reg;
                cmd.w_src     = j_reg;
                cmd.w_tgt     = k_reg;
                if (last_j)
                begin
                    j_next     = '0;
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg + 3'd1;
                end
            end

            // wait for the multiply and accumulate stages
            ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_WB;
                end
            end

            ST_WB:
            begin
                cmd.wb_en   = 1'b1;
                cmd.wb_bank = dst_bank_reg;
                cmd.wb_idx  = k_reg;
                if (last_k)
                begin
                    k_next        = '0;
                    src_bank_next = dst_bank_reg;
                    if (last_layer)
                    begin
                        state_next = ST_OUT_RD;
                    end
                    else
                    begin
                        layer_next    = layer_reg + 2'd1;
                        dst_bank_next = (dst_bank_reg == BANK_A) ? BANK_B : BANK_A;
                        state_next    = ST_MAC;
                    end
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_MAC;
                end
            end

            ST_OUT_RD:
            begin
                cmd.rd_bank = src_bank_reg;
                cmd.rd_idx  = k_reg;
                state_next  = ST_OUT_LOAD;
            end

            ST_OUT_LOAD:
            begin
                cmd.out_load = 1'b1;
                cmd.out_idx  = k_reg;
                cmd.out_last = last_out;
                state_next   = ST_OUT_SEND;
            end

            ST_OUT_SEND:
            begin
                if (!out_stall)
                begin
                    if (last_out)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 3'd1;
                        state_next = ST_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            layer_reg    <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            drain_reg    <= 1'b0;
            src_bank_reg <= BANK_INPUT;
            dst_bank_reg <= BANK_A;
        end
        else
        begin
            state_reg    <= state_next;
            layer_reg    <= layer_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            drain_reg    <= drain_next;
            src_bank_reg <= src_bank_next;
            dst_bank_reg <= dst_bank_next;
        end
    end

endmodule

@@ sv/linear_layered_network_inference.sv @@
// ----------------------------------------------------------------------------
// linear_layered_network_inference
// Fully connected layered network, forward pass without activation.
//
// Input channel (in_valid / in_stall / in_data): a word either writes one
// weight or stores one input element; the input word with vector_end set
// starts an inference. Weight and input words are accepted back to back.
// An inference runs layer by layer on one shared multiplier: for each target
// neuron it issues one multiply per source neuron, waits for the multiply
// and accumulate stages to drain, then writes the scaled sum back.
// Output channel (out_valid / out_stall / out_data): one word per output
// neuron in index order, each read, loaded and then offered; out_last marks
// the final one. The input side stalls from the start of an inference until
// the last result is taken, and a stalled result is held unchanged.
// Configuration (cfg_wr_en / cfg_index / cfg_data) must be written only
// while idle; the block does not enforce it. Reset restores three layers
// of eight neurons; weights and inputs must be written before use.
// ----------------------------------------------------------------------------
module linear_layered_network_inference (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  lli_pkg::in_word_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output lli_pkg::out_word_t                   out_data,
    input  logic                                 cfg_wr_en,
    input  logic [lli_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [lli_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import lli_pkg::*;

    dp_cmd_t cmd;

    lli_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd)
    );

    lli_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .out_data (out_data)
    );

endmodule
